// File: src/tbw_pkg.sv
package tbw_pkg;

  localparam int COORD_W      = 16;
  localparam int WEIGHT_W     = 32;
  localparam int DEF_COORD_FB = 4;
  localparam int DEF_WEIGHT_FB = 16;

  // width of the edge cross-product terms
  localparam int KW      = 2 * (COORD_W + 1) + 1;
  // quotient magnitude bits kept before saturation
  localparam int QW      = 34;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] cx_coord;
    logic signed [COORD_W-1:0] cy_coord;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } in_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
    logic                       degenerate;
  } out_t;

  typedef struct packed {
    logic signed [KW-1:0] kx;
    logic signed [KW-1:0] ky;
    logic signed [KW-1:0] kz;
  } kq_t;

endpackage

// File: src/tbw_front.sv
module tbw_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbw_pkg::in_t  in_data,
  output logic          full,
  input  logic          q_full,
  output logic          q_push,
  output tbw_pkg::kq_t  q_data
);
  import tbw_pkg::*;

  logic en;
  logic v1_r, v2_r, v3_r;
  logic signed [COORD_W:0] dx0_r, dx1_r, dx2_r, dy0_r, dy1_r, dy2_r;
  logic signed [2*COORD_W+1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  kq_t k_r;

  // hold the whole front while its last stage cannot drain
  assign en     = !(v3_r && q_full);
  assign full   = !en;
  assign q_push = en && v3_r;
  assign q_data = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0_r <= $signed({in_data.bx[COORD_W-1], in_data.bx})
             - $signed({in_data.ax[COORD_W-1], in_data.ax});
      dx1_r <= $signed({in_data.cx_coord[COORD_W-1], in_data.cx_coord})
             - $signed({in_data.ax[COORD_W-1], in_data.ax});
      dx2_r <= $signed({in_data.ax[COORD_W-1], in_data.ax})
             - $signed({in_data.px[COORD_W-1], in_data.px});
      dy0_r <= $signed({in_data.by_coord[COORD_W-1], in_data.by_coord})
             - $signed({in_data.ay[COORD_W-1], in_data.ay});
      dy1_r <= $signed({in_data.cy_coord[COORD_W-1], in_data.cy_coord})
             - $signed({in_data.ay[COORD_W-1], in_data.ay});
      dy2_r <= $signed({in_data.ay[COORD_W-1], in_data.ay})
             - $signed({in_data.py[COORD_W-1], in_data.py});

      p1_r <= dx1_r * dy2_r;
      p2_r <= dx2_r * dy1_r;
      p3_r <= dx2_r * dy0_r;
      p4_r <= dx0_r * dy2_r;
      p5_r <= dx0_r * dy1_r;
      p6_r <= dx1_r * dy0_r;

      k_r.kx <= KW'(p1_r) - KW'(p2_r);
      k_r.ky <= KW'(p3_r) - KW'(p4_r);
      k_r.kz <= KW'(p5_r) - KW'(p6_r);
    end
  end

endmodule

// File: src/tbw_queue.sv
module tbw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tbw_pkg::kq_t  din,
  input  logic          pop,
  output tbw_pkg::kq_t  dout,
  output logic          full,
  output logic          empty
);
  import tbw_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  kq_t           mem_r [Q_DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full  = (cnt_r == CW'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop)  rd_r <= (rd_r == PW'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

endmodule

// File: src/tbw_div.sv
module tbw_div #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          ovf_r [QW+1];
  logic [NW-1:0] hi;

  // a quotient that does not fit in QW bits only needs its overflow flag
  assign hi = num >> QW;

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (hi >= NW'(den));
      rem_r[0] <= hi[DW-1:0];
      lo_r[0]  <= num[QW-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] t;
    assign t = {rem_r[i-1], lo_r[i-1][QW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, den_r[i-1]}) begin
          rem_r[i] <= DW'(t - {1'b0, den_r[i-1]});
          q_r[i]   <= {q_r[i-1][QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= DW'(t);
          q_r[i]   <= {q_r[i-1][QW-2:0], 1'b0};
        end
        lo_r[i]  <= lo_r[i-1] << 1;
        den_r[i] <= den_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  assign quo = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// File: src/tbw_back.sv
module tbw_back #(
  parameter int COORD_FB  = tbw_pkg::DEF_COORD_FB,
  parameter int WEIGHT_FB = tbw_pkg::DEF_WEIGHT_FB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  tbw_pkg::kq_t  q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  localparam int NW = KW + 1 + WEIGHT_FB;
  localparam int DW = KW;
  localparam int SW = QW + 3;
  localparam logic signed [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(1) << WEIGHT_FB;
  localparam logic signed [SW-1:0]       ONE_S = SW'(1) << WEIGHT_FB;

  logic en;
  logic signed [KW:0]   sum_a;
  logic [KW:0]          mag_a;
  logic [KW-1:0]        mag_b, mag_c, mag_z;

  logic          v0_r, deg0_r, na0_r, nb0_r, nc0_r;
  logic [NW-1:0] numa_r, numb_r, numc_r;
  logic [DW-1:0] den_r;

  logic sv_r  [QW+1];
  logic sd_r  [QW+1];
  logic sna_r [QW+1];
  logic snb_r [QW+1];
  logic snc_r [QW+1];

  logic [QW-1:0] qa, qb, qc;
  logic          oa, ob, oc;
  logic signed [SW-1:0] wa, wb, wc;
  logic          out_v_r;
  out_t          out_r;

  // advance the back whenever the output slot is free or being drained
  assign en    = !out_v_r || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_v_r;
  assign out_data = out_r;

  function automatic logic signed [SW-1:0] apply_sign(
    input logic [QW-1:0] q, input logic o, input logic neg
  );
    logic [QW:0]          m;
    logic signed [SW-1:0] s;
    m = o ? ((QW + 1)'(1) << QW) : {1'b0, q};
    s = $signed(SW'(m));
    return neg ? -s : s;
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi_lim, lo_lim;
    hi_lim = SW'({1'b0, {(WEIGHT_W-1){1'b1}}});
    lo_lim = -hi_lim - SW'(1);
    if (v > hi_lim)      return {1'b0, {(WEIGHT_W-1){1'b1}}};
    else if (v < lo_lim) return {1'b1, {(WEIGHT_W-1){1'b0}}};
    else                 return WEIGHT_W'(v);
  endfunction

  assign sum_a = (KW + 1)'(q_data.kx) + (KW + 1)'(q_data.ky);
  assign mag_a = sum_a[KW] ? (KW + 1)'(-sum_a) : sum_a;
  assign mag_b = q_data.ky[KW-1] ? KW'(-q_data.ky) : q_data.ky;
  assign mag_c = q_data.kx[KW-1] ? KW'(-q_data.kx) : q_data.kx;
  assign mag_z = q_data.kz[KW-1] ? KW'(-q_data.kz) : q_data.kz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v0_r    <= !q_empty;
      out_v_r <= sv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numa_r <= NW'(mag_a) << WEIGHT_FB;
      numb_r <= NW'(mag_b) << WEIGHT_FB;
      numc_r <= NW'(mag_c) << WEIGHT_FB;
      den_r  <= mag_z;
      deg0_r <= (mag_z < (KW'(1) << (2 * COORD_FB)));
      na0_r  <= sum_a[KW] ^ q_data.kz[KW-1];
      nb0_r  <= q_data.ky[KW-1] ^ q_data.kz[KW-1];
      nc0_r  <= q_data.kx[KW-1] ^ q_data.kz[KW-1];
    end
  end

  // carry valid, flag and signs alongside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QW; i++) sv_r[i] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= v0_r;
      for (int i = 1; i <= QW; i++) sv_r[i] <= sv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0]  <= deg0_r;
      sna_r[0] <= na0_r;
      snb_r[0] <= nb0_r;
      snc_r[0] <= nc0_r;
      for (int i = 1; i <= QW; i++) begin
        sd_r[i]  <= sd_r[i-1];
        sna_r[i] <= sna_r[i-1];
        snb_r[i] <= snb_r[i-1];
        snc_r[i] <= snc_r[i-1];
      end
    end
  end

  tbw_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_a (
    .clk(clk), .en(en), .num(numa_r), .den(den_r), .quo(qa), .ovf(oa)
  );
  tbw_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_b (
    .clk(clk), .en(en), .num(numb_r), .den(den_r), .quo(qb), .ovf(ob)
  );
  tbw_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_c (
    .clk(clk), .en(en), .num(numc_r), .den(den_r), .quo(qc), .ovf(oc)
  );

  assign wa = ONE_S - apply_sign(qa, oa, sna_r[QW]);
  assign wb = apply_sign(qb, ob, snb_r[QW]);
  assign wc = apply_sign(qc, oc, snc_r[QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd_r[QW]) begin
        out_r.weight_a   <= -ONE_W;
        out_r.weight_b   <= ONE_W;
        out_r.weight_c   <= ONE_W;
        out_r.degenerate <= 1'b1;
      end else begin
        out_r.weight_a   <= sat(wa);
        out_r.weight_b   <= sat(wb);
        out_r.weight_c   <= sat(wc);
        out_r.degenerate <= 1'b0;
      end
    end
  end

endmodule

// File: src/triangle_barycentric_weights_core.sv
// Channel  Ports                      Accepted when
// input    push, full, in_data        push && !full
// result   empty, pop, out_data       pop && !empty
//
// One item per cycle sustained while results are popped; items are independent.
// 41 register stages lie between the input and result ports: 3 front stages
// (differences, products, cross terms), the 4-entry queue, 1 prep stage,
// 35 restoring divider stages, 1 output.
// Reset (rst_n low, synchronous) clears all valid bits and the queue.
// A held result stalls only the back; the front keeps filling the queue.
module triangle_barycentric_weights_core #(
  parameter int COORD_FRAC_BITS  = tbw_pkg::DEF_COORD_FB,
  parameter int WEIGHT_FRAC_BITS = tbw_pkg::DEF_WEIGHT_FB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  tbw_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  logic q_push, q_pop, q_full, q_empty;
  kq_t  q_din, q_dout;

  tbw_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .in_data(in_data), .full(full),
    .q_full(q_full), .q_push(q_push), .q_data(q_din)
  );

  tbw_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .pop(q_pop),
    .dout(q_dout), .full(q_full), .empty(q_empty)
  );

  tbw_back #(.COORD_FB(COORD_FRAC_BITS), .WEIGHT_FB(WEIGHT_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_dout), .q_pop(q_pop),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

endmodule
